### sv/mftep_pkg.sv
// ----------------------------------------------------------------------------
// mftep_pkg
// shared types and constants of the midi file track event parser
// ----------------------------------------------------------------------------
`default_nettype none

package mftep_pkg;

  localparam int MAX_VLQ_BYTES_DEF = 4;
  localparam int VLQ_CNT_W         = 2;
  localparam int DELTA_W           = 28;
  localparam int OUT_DATA_W        = 56;

  localparam logic [7:0] STATUS_MIN   = 8'h80;
  localparam logic [7:0] VOICE_MAX    = 8'hEF;
  localparam logic [7:0] SYSTEM_MIN   = 8'hF0;
  localparam logic [7:0] META_STATUS  = 8'hFF;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_PRESSURE  = 4'hD;

  typedef enum logic [1:0] {
    KIND_VOICE     = 2'd0,
    KIND_END       = 2'd1,
    KIND_NO_STATUS = 2'd2,
    KIND_SYSTEM    = 2'd3
  } event_kind_t;

  typedef enum logic [7:0] {
    PH_DELTA     = 8'b0000_0001,
    PH_STATUS    = 8'b0000_0010,
    PH_DATA1     = 8'b0000_0100,
    PH_DATA2     = 8'b0000_1000,
    PH_META_TYPE = 8'b0001_0000,
    PH_META_LEN  = 8'b0010_0000,
    PH_META_SKIP = 8'b0100_0000,
    PH_HALTED    = 8'b1000_0000
  } phase_t;

  function automatic logic one_data_byte(input logic [7:0] st);
    return (st[7:4] == HI_PROGRAM) || (st[7:4] == HI_PRESSURE);
  endfunction

endpackage

`default_nettype wire

### sv/midi_file_track_event_parser_unit.sv
// ----------------------------------------------------------------------------
// midi_file_track_event_parser_unit
// parses a standard midi file track one byte per word into decoded events
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one track byte per word; s_axis_tuser high means restart,
//   which clears the parser and running status (also after end of track)
//   m_axis carries one decoded event per word, kind in m_axis_tuser
//   a word is taken in an input register, parsed by the state logic once the
//   output register can take a word, and the event, if any, lands in the
//   output register
//   throughput is one byte per cycle while m_axis does not stall, set by the
//   single parser state update per byte; bytes that give no event (delta,
//   meta, first data byte) are consumed without showing anything on m_axis
//   when m_axis stalls, the output register holds its word and the input
//   register holds one more byte; s_axis_tready falls only while both are full
//   rst clears the parser state and both valid flags; s_axis_tready is high
//   from the first cycle after reset
// ----------------------------------------------------------------------------
`default_nettype none

module midi_file_track_event_parser_unit
  import mftep_pkg::*;
#(
  parameter int MAX_VLQ_BYTES = MAX_VLQ_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // track_byte
  input  wire logic                  s_axis_tuser,   // req_type
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // delta_ticks, status_value, first_data, second_data, data_count,
  // status_implied, zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [1:0]                 m_axis_tuser    // event_kind
);

  logic                 in_valid;
  logic                 in_restart;
  logic [7:0]           in_byte;

  phase_t               phase, phase_next;
  logic [DELTA_W-1:0]   delta_accum, delta_accum_next;
  logic [VLQ_CNT_W-1:0] vlq_count, vlq_count_next;
  logic [7:0]           running_status, running_status_next;
  logic [6:0]           held_first_data, held_first_data_next;
  logic [DELTA_W-1:0]   meta_skip_left, meta_skip_left_next;
  logic                 current_implied, current_implied_next;

  logic                 out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  event_kind_t          out_kind;

  logic                 advance;
  logic                 fire;
  logic [VLQ_CNT_W:0]   vlq_inc;
  logic                 vlq_last;
  logic [DELTA_W-1:0]   delta_shift;
  logic [DELTA_W-1:0]   skip_shift;
  logic [DELTA_W-1:0]   skip_dec;

  logic                 emit;
  event_kind_t          e_kind;
  logic [7:0]           e_status;
  logic [6:0]           e_first;
  logic [6:0]           e_second;
  logic [1:0]           e_count;
  logic                 e_implied;

  assign advance       = !out_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  assign vlq_inc     = {1'b0, vlq_count} + (VLQ_CNT_W+1)'(1);
  assign vlq_last    = !in_byte[7] || (vlq_inc >= (VLQ_CNT_W+1)'(MAX_VLQ_BYTES));
  assign delta_shift = {delta_accum[DELTA_W-8:0], in_byte[6:0]};
  assign skip_shift  = {meta_skip_left[DELTA_W-8:0], in_byte[6:0]};
  assign skip_dec    = meta_skip_left - DELTA_W'(1);

  always_comb begin
    phase_next           = phase;
    delta_accum_next     = delta_accum;
    vlq_count_next       = vlq_count;
    running_status_next  = running_status;
    held_first_data_next = held_first_data;
    meta_skip_left_next  = meta_skip_left;
    current_implied_next = current_implied;
    emit      = 1'b0;
    e_kind    = KIND_VOICE;
    e_status  = '0;
    e_first   = '0;
    e_second  = '0;
    e_count   = '0;
    e_implied = 1'b0;

    if (in_restart) begin
      phase_next           = PH_DELTA;
      delta_accum_next     = '0;
      vlq_count_next       = '0;
      running_status_next  = '0;
      held_first_data_next = '0;
      meta_skip_left_next  = '0;
      current_implied_next = 1'b0;
    end else begin
      unique case (phase)
        PH_HALTED: begin
        end
        PH_STATUS: begin
          if (in_byte >= STATUS_MIN && in_byte <= VOICE_MAX) begin
            running_status_next  = in_byte;
            current_implied_next = 1'b0;
            phase_next           = PH_DATA1;
          end else if (in_byte == META_STATUS) begin
            phase_next = PH_META_TYPE;
          end else if (in_byte >= SYSTEM_MIN) begin
            running_status_next = '0;
            emit     = 1'b1;
            e_kind   = KIND_SYSTEM;
            e_status = in_byte;
            phase_next       = PH_DELTA;
            delta_accum_next = '0;
            vlq_count_next   = '0;
          end else if (running_status == '0) begin
            emit    = 1'b1;
            e_kind  = KIND_NO_STATUS;
            e_first = in_byte[6:0];
            phase_next       = PH_DELTA;
            delta_accum_next = '0;
            vlq_count_next   = '0;
          end else begin
            current_implied_next = 1'b1;
            held_first_data_next = in_byte[6:0];
            if (one_data_byte(running_status)) begin
              emit      = 1'b1;
              e_kind    = KIND_VOICE;
              e_status  = running_status;
              e_first   = in_byte[6:0];
              e_count   = 2'd1;
              e_implied = 1'b1;
              phase_next       = PH_DELTA;
              delta_accum_next = '0;
              vlq_count_next   = '0;
            end else begin
              phase_next = PH_DATA2;
            end
          end
        end
        PH_DATA1: begin
          held_first_data_next = in_byte[6:0];
          if (one_data_byte(running_status)) begin
            emit      = 1'b1;
            e_kind    = KIND_VOICE;
            e_status  = running_status;
            e_first   = in_byte[6:0];
            e_count   = 2'd1;
            e_implied = current_implied;
            phase_next       = PH_DELTA;
            delta_accum_next = '0;
            vlq_count_next   = '0;
          end else begin
            phase_next = PH_DATA2;
          end
        end
        PH_DATA2: begin
          emit      = 1'b1;
          e_kind    = KIND_VOICE;
          e_status  = running_status;
          e_first   = held_first_data;
          e_second  = in_byte[6:0];
          e_count   = 2'd2;
          e_implied = current_implied;
          phase_next       = PH_DELTA;
          delta_accum_next = '0;
          vlq_count_next   = '0;
        end
        PH_META_TYPE: begin
          if (in_byte == META_EOT) begin
            emit       = 1'b1;
            e_kind     = KIND_END;
            phase_next = PH_HALTED;
          end else begin
            meta_skip_left_next = '0;
            vlq_count_next      = '0;
            phase_next          = PH_META_LEN;
          end
        end
        PH_META_LEN: begin
          meta_skip_left_next = skip_shift;
          vlq_count_next      = vlq_inc[VLQ_CNT_W-1:0];
          if (vlq_last) begin
            if (skip_shift == '0) begin
              phase_next       = PH_DELTA;
              delta_accum_next = '0;
              vlq_count_next   = '0;
            end else begin
              phase_next = PH_META_SKIP;
            end
          end
        end
        PH_META_SKIP: begin
          meta_skip_left_next = skip_dec;
          if (skip_dec == '0) begin
            phase_next       = PH_DELTA;
            delta_accum_next = '0;
            vlq_count_next   = '0;
          end
        end
        PH_DELTA: begin
          delta_accum_next = delta_shift;
          if (vlq_last) begin
            vlq_count_next = '0;
            phase_next     = PH_STATUS;
          end else begin
            vlq_count_next = vlq_inc[VLQ_CNT_W-1:0];
          end
        end
        default: begin
          phase_next       = PH_DELTA;
          delta_accum_next = '0;
          vlq_count_next   = '0;
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_restart <= s_axis_tuser;
      in_byte    <= s_axis_tdata;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_DELTA;
      delta_accum     <= '0;
      vlq_count       <= '0;
      running_status  <= '0;
      held_first_data <= '0;
      meta_skip_left  <= '0;
      current_implied <= 1'b0;
    end else if (fire) begin
      phase           <= phase_next;
      delta_accum     <= delta_accum_next;
      vlq_count       <= vlq_count_next;
      running_status  <= running_status_next;
      held_first_data <= held_first_data_next;
      meta_skip_left  <= meta_skip_left_next;
      current_implied <= current_implied_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_kind <= e_kind;
      out_data <= {3'b000, e_implied, e_count, e_second, e_first, e_status,
                   delta_accum};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_kind;

endmodule

`default_nettype wire

### sv/mftep_checker.sv
// ----------------------------------------------------------------------------
// mftep_checker
// port level checks of the midi file track event parser
// ----------------------------------------------------------------------------
`default_nettype none

module mftep_checker
  import mftep_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [7:0]            s_axis_tdata,
  input wire logic                  s_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [1:0]            m_axis_tuser
);

  logic       in_take;
  logic [7:0] st;
  logic [6:0] d2;
  logic [1:0] cnt;
  logic       imp;

  assign in_take = s_axis_tvalid && s_axis_tready && (s_axis_tdata != 8'h00 || s_axis_tuser);
  assign st      = m_axis_tdata[35:28];
  assign d2      = m_axis_tdata[49:43];
  assign cnt     = m_axis_tdata[51:50];
  assign imp     = m_axis_tdata[52];

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("output valid or input stalled after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_voice: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_VOICE |->
      st[7] && (cnt == 2'd1 || cnt == 2'd2) && (cnt == 2'd2 || d2 == 7'd0))
    else $error("malformed voice event");

  a_other: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_VOICE |->
      cnt == 2'd0 && !imp && d2 == 7'd0 && (m_axis_tuser == KIND_SYSTEM || st == 8'h00)
      && !(in_take && 1'b0))
    else $error("malformed non-voice event");

endmodule

bind midi_file_track_event_parser_unit mftep_checker u_mftep_checker (.*);

`default_nettype wire

### sim/midi_track_event_checker.sv
// ----------------------------------------------------------------------------
// midi_track_event_checker
// watches both stream ports of the track event parser, predicts each decoded
// event from the accepted track bytes and compares it field by field
// ----------------------------------------------------------------------------
`default_nettype none

module midi_track_event_checker
  import mftep_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // track_byte
  input  wire logic                  s_axis_tuser,   // req_type
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // delta_ticks, status_value, first_data, second_data, data_count,
  // status_implied, zero fill
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic [1:0]            m_axis_tuser,   // event_kind
  output int                         fail_count,
  output int                         events_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    event_kind_t        kind;
    logic [DELTA_W-1:0] delta;
    logic [7:0]         status;
    logic [6:0]         data1;
    logic [6:0]         data2;
    logic [1:0]         count;
    logic               implied;
  } track_event_t;

  track_event_t       awaited_events[$];

  phase_t             phase;
  logic [DELTA_W-1:0] delta_acc;
  logic [2:0]         vlq_count;
  logic [7:0]         run_status;
  logic [6:0]         held_data1;
  logic [DELTA_W-1:0] skip_left;
  logic               implied_now;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_parser();
    phase       = PH_DELTA;
    delta_acc   = '0;
    vlq_count   = '0;
    run_status  = '0;
    held_data1  = '0;
    skip_left   = '0;
    implied_now = 1'b0;
  endtask

  task automatic restart_delta();
    phase     = PH_DELTA;
    delta_acc = '0;
    vlq_count = '0;
  endtask

  // program change and channel pressure carry a single data byte
  function automatic logic single_data(input logic [7:0] st);
    return st[7:5] == 3'b110;
  endfunction

  function automatic logic vlq_done(input logic [7:0] b);
    vlq_count = vlq_count + 3'd1;
    return !b[7] || (vlq_count >= 3'(MAX_VLQ_BYTES_DEF));
  endfunction

  task automatic queue_event(input event_kind_t kind, input logic [7:0] status,
                             input logic [6:0] data1, input logic [6:0] data2,
                             input logic [1:0] count, input logic implied);
    track_event_t ev;
    ev.kind    = kind;
    ev.delta   = delta_acc;
    ev.status  = status;
    ev.data1   = data1;
    ev.data2   = data2;
    ev.count   = count;
    ev.implied = implied;
    awaited_events.push_back(ev);
  endtask

  task automatic parse_track_byte(input logic restart, input logic [7:0] b);
    if (restart) begin
      clear_parser();
      return;
    end
    case (phase)
      PH_HALTED: ;
      PH_STATUS: begin
        if (b >= STATUS_MIN && b <= VOICE_MAX) begin
          run_status  = b;
          implied_now = 1'b0;
          phase       = PH_DATA1;
        end else if (b == META_STATUS) begin
          phase = PH_META_TYPE;
        end else if (b >= SYSTEM_MIN) begin
          run_status = '0;
          queue_event(KIND_SYSTEM, b, '0, '0, 2'd0, 1'b0);
          restart_delta();
        end else if (run_status == '0) begin
          queue_event(KIND_NO_STATUS, '0, b[6:0], '0, 2'd0, 1'b0);
          restart_delta();
        end else begin
          implied_now = 1'b1;
          held_data1  = b[6:0];
          if (single_data(run_status)) begin
            queue_event(KIND_VOICE, run_status, held_data1, '0, 2'd1, 1'b1);
            restart_delta();
          end else begin
            phase = PH_DATA2;
          end
        end
      end
      PH_DATA1: begin
        held_data1 = b[6:0];
        if (single_data(run_status)) begin
          queue_event(KIND_VOICE, run_status, held_data1, '0, 2'd1, implied_now);
          restart_delta();
        end else begin
          phase = PH_DATA2;
        end
      end
      PH_DATA2: begin
        queue_event(KIND_VOICE, run_status, held_data1, b[6:0], 2'd2, implied_now);
        restart_delta();
      end
      PH_META_TYPE: begin
        if (b == META_EOT) begin
          queue_event(KIND_END, '0, '0, '0, 2'd0, 1'b0);
          phase = PH_HALTED;
        end else begin
          skip_left = '0;
          vlq_count = '0;
          phase     = PH_META_LEN;
        end
      end
      PH_META_LEN: begin
        skip_left = {skip_left[DELTA_W-8:0], b[6:0]};
        if (vlq_done(b)) begin
          if (skip_left == '0) restart_delta();
          else phase = PH_META_SKIP;
        end
      end
      PH_META_SKIP: begin
        skip_left = skip_left - DELTA_W'(1);
        if (skip_left == '0) restart_delta();
      end
      default: begin
        delta_acc = {delta_acc[DELTA_W-8:0], b[6:0]};
        if (vlq_done(b)) begin
          vlq_count = '0;
          phase     = PH_STATUS;
        end else begin
          phase = PH_DELTA;
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [DELTA_W-1:0] got,
                               input logic [DELTA_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic check_event(input logic [OUT_DATA_W-1:0] word, input logic [1:0] kind);
    track_event_t want;
    if (awaited_events.size() == 0) begin
      report_mismatch($sformatf("event word %0h kind %0d with none awaited", word, kind));
      return;
    end
    want = awaited_events.pop_front();
    compare_field("event_kind", DELTA_W'(kind), DELTA_W'(want.kind));
    compare_field("delta_ticks", word[27:0], want.delta);
    compare_field("status_value", DELTA_W'(word[35:28]), DELTA_W'(want.status));
    compare_field("first_data", DELTA_W'(word[42:36]), DELTA_W'(want.data1));
    compare_field("second_data", DELTA_W'(word[49:43]), DELTA_W'(want.data2));
    compare_field("data_count", DELTA_W'(word[51:50]), DELTA_W'(want.count));
    compare_field("status_implied", DELTA_W'(word[52]), DELTA_W'(want.implied));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      awaited_events.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_event(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) parse_track_byte(s_axis_tuser, s_axis_tdata);
    end
    events_pending <= awaited_events.size();
  end

endmodule

`default_nettype wire

### sim/midi_file_track_event_parser_unit_test.sv
// ----------------------------------------------------------------------------
// midi_file_track_event_parser_unit_test
// drives track bytes into the parser with random gaps and output stalls:
// a short directed track, then random well formed events mixed with noise,
// restarts and end of track; a checker module predicts and compares events
// ----------------------------------------------------------------------------
`default_nettype none

module midi_file_track_event_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mftep_pkg::*;

  localparam logic REQ_TRACK   = 1'b0;
  localparam logic REQ_RESTART = 1'b1;
  localparam int   TRACK_WORDS = 1176;

  localparam logic [7:0] OPENING_TRACK [25] = '{
    8'h00, 8'h90, 8'h3C, 8'h7F,
    8'h00, 8'h40, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hC5, 8'hFF,
    8'h00, 8'hF0,
    8'h00, 8'h45,
    8'h00, 8'hFF, 8'h01, 8'h00,
    8'h00, 8'hFF, 8'h2F,
    8'h90
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  s_axis_tuser = REQ_TRACK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  int fail_count;
  int events_pending;
  int sent_words = 0;
  bit quiet = 1'b0;

  always #6 clk = ~clk;

  midi_file_track_event_parser_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  midi_track_event_checker event_check (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .fail_count     (fail_count),
    .events_pending (events_pending)
  );

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic req, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_words++;
  endtask

  function automatic logic [7:0] data_byte();
    if ($urandom_range(0, 99) < 6) return 8'($urandom);
    return {1'b0, 7'($urandom)};
  endfunction

  task automatic send_delta();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = (r < 60) ? 1 : (r < 80) ? 2 : (r < 92) ? 3 : 4;
    for (int i = 0; i < n - 1; i++) send_word(REQ_TRACK, {1'b1, 7'($urandom)});
    // the last allowed byte ends the delta even with its top bit set
    if (n == 4 && $urandom_range(0, 1) == 1) send_word(REQ_TRACK, {1'b1, 7'($urandom)});
    else send_word(REQ_TRACK, {1'b0, 7'($urandom)});
  endtask

  // output side stalls
  initial begin
    int gap;
    wait (rst == 1'b0);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int         pick;
    int         len;
    logic [7:0] st;
    logic [7:0] run_st;
    bit         running;
    running = 1'b0;
    run_st  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (OPENING_TRACK[i]) send_word(REQ_TRACK, OPENING_TRACK[i]);
    send_word(REQ_RESTART, 8'($urandom));

    while (sent_words < TRACK_WORDS) begin
      if ($urandom_range(0, 149) == 0) quiet = ~quiet;
      pick = $urandom_range(0, 99);
      if (pick < 34) begin
        send_delta();
        st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
        send_word(REQ_TRACK, st);
        send_word(REQ_TRACK, data_byte());
        if (st[7:5] != 3'b110) send_word(REQ_TRACK, data_byte());
        running = 1'b1;
        run_st  = st;
      end else if (pick < 60 && running) begin
        send_delta();
        send_word(REQ_TRACK, {1'b0, 7'($urandom)});
        if (run_st[7:5] != 3'b110) send_word(REQ_TRACK, data_byte());
      end else if (pick < 72) begin
        send_delta();
        send_word(REQ_TRACK, META_STATUS);
        st = 8'($urandom);
        send_word(REQ_TRACK, (st == META_EOT) ? 8'h01 : st);
        if ($urandom_range(0, 99) < 90) begin
          len = $urandom_range(0, 6);
          send_word(REQ_TRACK, 8'(len));
        end else begin
          len = 128 + $urandom_range(0, 16);
          send_word(REQ_TRACK, 8'h81);
          send_word(REQ_TRACK, 8'(len - 128));
        end
        repeat (len) send_word(REQ_TRACK, 8'($urandom));
      end else if (pick < 78) begin
        send_delta();
        send_word(REQ_TRACK, 8'($urandom_range(SYSTEM_MIN, META_STATUS - 1)));
        running = 1'b0;
      end else if (pick < 82) begin
        send_delta();
        send_word(REQ_TRACK, {1'b0, 7'($urandom)});
      end else if (pick < 85) begin
        send_delta();
        send_word(REQ_TRACK, META_STATUS);
        send_word(REQ_TRACK, META_EOT);
        repeat ($urandom_range(0, 4)) send_word(REQ_TRACK, 8'($urandom));
        send_word(REQ_RESTART, 8'($urandom));
        running = 1'b0;
      end else if (pick < 88) begin
        // restart in the middle of an event
        repeat ($urandom_range(0, 3)) send_word(REQ_TRACK, 8'($urandom));
        send_word(REQ_RESTART, 8'($urandom));
        running = 1'b0;
      end else begin
        send_word(REQ_TRACK, 8'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (events_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
